FILE: design/mfwl_pkg.sv
// Package for the 68k flag-write lookahead core.
// Holds the opcode decode table, lookahead phase codes and extension-word helpers.
// No dependencies.
package mfwl_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_NEXTOP = 3'd1,
        PH_BRIEF  = 3'd2,
        PH_BR16   = 3'd3,
        PH_BR32HI = 3'd4,
        PH_BR32LO = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        K_EA     = 3'd0,
        K_MOVEA  = 3'd1,
        K_ADDA   = 3'd2,
        K_W1     = 3'd3,
        K_W2     = 3'd4,
        K_W3     = 3'd5,
        K_BRANCH = 3'd6
    } t_handler;

    // Action code: bit 5 set means flag-neutral, bits 2..0 pick the handler.
    // Otherwise bits 4..0 are the flag mask that the instruction writes.
    localparam logic [5:0] A_F4     = 6'd15;
    localparam logic [5:0] A_F5     = 6'd31;
    localparam logic [5:0] A_EA     = 6'd32;
    localparam logic [5:0] A_MOVEA  = 6'd33;
    localparam logic [5:0] A_ADDA   = 6'd34;
    localparam logic [5:0] A_W1     = 6'd35;
    localparam logic [5:0] A_W2     = 6'd36;
    localparam logic [5:0] A_W3     = 6'd37;
    localparam logic [5:0] A_BRANCH = 6'd38;

    typedef struct packed {
        logic [3:0]  line;
        logic [15:0] mask;
        logic [15:0] match;
        logic [5:0]  act;
    } t_entry;

    localparam int TABLE_LEN = 95;

    localparam t_entry DECODE_TABLE [TABLE_LEN] = '{
        '{4'd0,16'hffbf,16'h003c,6'd0},'{4'd0,16'hff00,16'h0000,A_F4},
        '{4'd0,16'hffbf,16'h023c,6'd0},'{4'd0,16'hf9c0,16'h00c0,A_F4},
        '{4'd0,16'hff00,16'h0200,A_F4},'{4'd0,16'hff00,16'h0400,A_F5},
        '{4'd0,16'hffc0,16'h06c0,6'd0},'{4'd0,16'hff00,16'h0600,A_F5},
        '{4'd0,16'hffbf,16'h0a3c,6'd0},'{4'd0,16'hff00,16'h0a00,A_F4},
        '{4'd0,16'hff00,16'h0c00,A_F4},'{4'd0,16'hff00,16'h0800,6'd4},
        '{4'd0,16'hf9c0,16'h08c0,A_F4},'{4'd0,16'hf100,16'h0100,6'd4},
        '{4'd1,16'hc1c0,16'h0040,A_MOVEA},'{4'd1,16'hc000,16'h0000,A_F4},
        '{4'd2,16'hc1c0,16'h0040,A_MOVEA},'{4'd2,16'hc000,16'h0000,A_F4},
        '{4'd3,16'hc1c0,16'h0040,A_MOVEA},'{4'd3,16'hc000,16'h0000,A_F4},
        '{4'd4,16'hfdc0,16'h40c0,6'd0},'{4'd4,16'hff00,16'h4000,A_F5},
        '{4'd4,16'hff00,16'h4200,A_F4},'{4'd4,16'hffc0,16'h44c0,A_F5},
        '{4'd4,16'hff00,16'h4400,A_F5},'{4'd4,16'hffc0,16'h46c0,A_F5},
        '{4'd4,16'hff00,16'h4600,A_F4},'{4'd4,16'hfeb8,16'h4880,A_F4},
        '{4'd4,16'hfff8,16'h4808,A_W3},'{4'd4,16'hffc0,16'h4800,A_F5},
        '{4'd4,16'hfff8,16'h4840,A_F4},'{4'd4,16'hfff8,16'h4848,6'd0},
        '{4'd4,16'hffc0,16'h4840,A_EA},'{4'd4,16'hffff,16'h4afc,6'd0},
        '{4'd4,16'hff00,16'h4a00,A_F4},'{4'd4,16'hff80,16'h4c00,A_F4},
        '{4'd4,16'hfff0,16'h4e40,6'd0},'{4'd4,16'hfff8,16'h4e50,A_W2},
        '{4'd4,16'hfff8,16'h4e58,A_W1},'{4'd4,16'hfff0,16'h4e60,6'd0},
        '{4'd4,16'hffff,16'h4e70,6'd0},'{4'd4,16'hffff,16'h4e71,A_W1},
        '{4'd4,16'hffff,16'h4e72,A_F5},'{4'd4,16'hffff,16'h4e73,A_F5},
        '{4'd4,16'hffff,16'h4e74,6'd0},'{4'd4,16'hffff,16'h4e75,6'd0},
        '{4'd4,16'hffff,16'h4e76,6'd0},'{4'd4,16'hffff,16'h4e77,A_F5},
        '{4'd4,16'hfffe,16'h4e7a,6'd0},'{4'd4,16'hffc0,16'h4e80,6'd0},
        '{4'd4,16'hffc0,16'h4ec0,6'd0},'{4'd4,16'hfb80,16'h4880,A_W2},
        '{4'd4,16'hf1c0,16'h41c0,A_EA},'{4'd4,16'hf140,16'h4100,6'd0},
        '{4'd5,16'hf0c0,16'h50c0,6'd0},'{4'd5,16'hf038,16'h5008,A_W1},
        '{4'd5,16'hf000,16'h5000,A_F5},
        '{4'd6,16'hfe00,16'h6000,A_BRANCH},'{4'd6,16'hf000,16'h6000,6'd0},
        '{4'd7,16'hf000,16'h7000,A_F4},
        '{4'd8,16'hf1c0,16'h80c0,A_F4},'{4'd8,16'hf1f0,16'h8100,A_F5},
        '{4'd8,16'hf1f0,16'h8140,6'd0},'{4'd8,16'hf1f0,16'h8180,6'd0},
        '{4'd8,16'hf1c0,16'h81c0,A_F4},'{4'd8,16'hf000,16'h8000,A_F4},
        '{4'd9,16'hf0c0,16'h90c0,A_ADDA},'{4'd9,16'hf130,16'h9100,A_F4},
        '{4'd9,16'hf000,16'h9000,A_F5},
        '{4'd11,16'hf000,16'hb000,A_F4},
        '{4'd12,16'hf1c0,16'hc0c0,A_F4},'{4'd12,16'hf1f0,16'hc100,A_F5},
        '{4'd12,16'hf1c0,16'hc1c0,A_F4},'{4'd12,16'hf1f0,16'hc140,A_W1},
        '{4'd12,16'hf1f0,16'hc180,A_W1},'{4'd12,16'hf000,16'hc000,A_F4},
        '{4'd13,16'hf0c0,16'hd0c0,A_ADDA},'{4'd13,16'hf130,16'hd100,A_F4},
        '{4'd13,16'hf000,16'hd000,A_F5},
        '{4'd14,16'hfec0,16'he0c0,A_F5},'{4'd14,16'hfec0,16'he2c0,A_F5},
        '{4'd14,16'hfec0,16'he4c0,A_F4},'{4'd14,16'hfec0,16'he6c0,A_F4},
        '{4'd14,16'hffc0,16'he8c0,A_F4},'{4'd14,16'hffc0,16'he9c0,A_F4},
        '{4'd14,16'hffc0,16'heac0,A_F4},'{4'd14,16'hffc0,16'hebc0,A_F4},
        '{4'd14,16'hffc0,16'hecc0,A_F4},'{4'd14,16'hffc0,16'hedc0,A_F4},
        '{4'd14,16'hffc0,16'heec0,A_F4},'{4'd14,16'hffc0,16'hefc0,A_F4},
        '{4'd14,16'hf018,16'he000,A_F5},'{4'd14,16'hf018,16'he008,A_F5},
        '{4'd14,16'hf018,16'he010,A_F4},'{4'd14,16'hf018,16'he018,A_F4}
    };

    // First matching entry wins; scanning from the end lets earlier hits override.
    function automatic logic [5:0] decode_act(input logic [15:0] w);
        logic [5:0] act;
        act = 6'd0;
        for (int i = TABLE_LEN - 1; i >= 0; i--) begin
            if (DECODE_TABLE[i].line == w[15:12] &&
                (w & DECODE_TABLE[i].mask) == DECODE_TABLE[i].match) begin
                act = DECODE_TABLE[i].act;
            end
        end
        return act;
    endfunction

    // Instruction length in words: the opcode plus its source extension words.
    // imm_bytes is 0, 2 or 4 and only matters for the immediate mode.
    function automatic logic [2:0] ea_words(input logic [15:0] opcode,
                                            input logic [15:0] brief,
                                            input logic [2:0]  imm_bytes);
        logic [2:0] n;
        logic [2:0] mode;
        logic [2:0] rg;
        mode = opcode[5:3];
        rg   = opcode[2:0];
        n    = 3'd1;
        if (mode == 3'd5) begin
            n = 3'd2;
        end else if (mode == 3'd6 || (mode == 3'd7 && rg == 3'd3)) begin
            n = 3'd2;
            if (brief[1:0] == 2'd2) n = n + 3'd1;
            else if (brief[1:0] == 2'd3) n = n + 3'd2;
            if (brief[5:4] == 2'd2) n = n + 3'd1;
            else if (brief[5:4] == 2'd3) n = n + 3'd2;
        end else if (mode == 3'd7) begin
            if (rg == 3'd0 || rg == 3'd2) n = 3'd2;
            else if (rg == 3'd1) n = 3'd3;
            else if (rg == 3'd4) begin
                if (imm_bytes == 3'd4) n = 3'd3;
                else if (imm_bytes != 3'd0) n = 3'd2;
            end
        end
        return n;
    endfunction

endpackage

FILE: design/m68k_flag_write_mask_lookahead_core.sv
// Top level of the 68k flag-write lookahead core.
// Decodes one instruction word per item and tracks the lookahead walk.
// Depends on mfwl_pkg.
//
// Usage: the host starts a query by sending an item with i_op = 0 and the
// opcode word at offset 0. Each accepted item produces exactly one result
// item. A result with o_kind = 0 asks for the word at byte offset
// o_fetch_offset (relative to the start instruction, modulo 2^32); the host
// answers with an item carrying i_op = 1 and that word. A result with
// o_kind = 1 carries the final o_flag_mask (bit 0 C up to bit 4 X).
// An item with i_op = 0 drops any query in progress.
//
// The result of an item is held in the output register from the edge after it is
// accepted. Throughput is one item per cycle while the receiver does not stall; the
// table match and the offset add sit between the walk state and the output
// register, so the state is ready for the next word at the next edge.
// When the receiver stalls, the output register holds its item and o_in_stall
// rises, so no new item is taken until the waiting result moves on.
//
// Reset clears the walk state to idle and sets max_depth back to 4. The user must
// set max_depth (i_cfg_wr_en, i_cfg_wr_data) only while the core is idle; unchecked.
module m68k_flag_write_mask_lookahead_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [15:0] i_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic signed [31:0] o_fetch_offset,
    output logic [4:0]  o_flag_mask
);
    import mfwl_pkg::*;

    logic [3:0]  r_max_depth;
    t_phase      r_phase, n_phase;
    logic [31:0] r_cursor, n_cursor;
    logic [3:0]  r_nest, n_nest;
    logic [15:0] r_opcode, n_opcode;
    logic [15:0] r_disp_high, n_disp_high;

    logic        r_out_valid;
    logic        r_kind, n_kind;
    logic [31:0] r_fetch, n_fetch;
    logic [4:0]  r_mask, n_mask;

    logic        accept;
    logic [5:0]  act;
    logic [7:0]  low;
    logic        do_dispatch;
    logic        top;
    logic        go;
    logic [31:0] go_base;
    logic [31:0] go_bytes;
    logic [2:0]  imm;
    logic        ea_path;
    logic [31:0] base;

    // A new item may enter unless a result is still waiting and stalled.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign act        = decode_act(i_word);
    assign low        = i_word[7:0];

    always_comb begin
        n_phase     = r_phase;
        n_cursor    = r_cursor;
        n_nest      = r_nest;
        n_opcode    = r_opcode;
        n_disp_high = r_disp_high;
        n_kind      = 1'b1;
        n_fetch     = 32'd0;
        n_mask      = 5'd0;
        do_dispatch = 1'b0;
        top         = 1'b0;
        go          = 1'b0;
        go_base     = r_cursor;
        go_bytes    = 32'd0;
        imm         = 3'd0;
        ea_path     = 1'b0;
        base        = r_cursor;

        if (!i_op) begin
            do_dispatch = 1'b1;
            top         = 1'b1;
            base        = 32'd0;
            n_cursor    = 32'd0;
            n_nest      = 4'd0;
        end else begin
            unique case (r_phase)
                PH_NEXTOP: begin
                    do_dispatch = 1'b1;
                end
                PH_BRIEF: begin
                    go       = 1'b1;
                    go_bytes = {28'd0, ea_words(r_opcode, i_word, 3'd0), 1'b0};
                end
                PH_BR16: begin
                    go       = 1'b1;
                    go_bytes = {{16{i_word[15]}}, i_word};
                end
                PH_BR32HI: begin
                    n_disp_high = i_word;
                    n_phase     = PH_BR32LO;
                    n_kind      = 1'b0;
                    n_fetch     = r_cursor + 32'd2;
                end
                PH_BR32LO: begin
                    go       = 1'b1;
                    go_bytes = {r_disp_high, i_word};
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (do_dispatch) begin
            go_base = base;
            if (!act[5]) begin
                n_mask  = act[4:0];
                n_phase = PH_IDLE;
            end else if (!top && r_nest >= r_max_depth) begin
                n_phase = PH_IDLE;
            end else begin
                if (!top) n_nest = r_nest + 4'd1;
                n_opcode = i_word;
                unique case (t_handler'(act[2:0]))
                    K_W1: begin
                        go = 1'b1; go_bytes = 32'd2;
                    end
                    K_W2: begin
                        go = 1'b1; go_bytes = 32'd4;
                    end
                    K_W3: begin
                        go = 1'b1; go_bytes = 32'd6;
                    end
                    K_BRANCH: begin
                        // The displacement is relative to the word after the opcode.
                        n_cursor = base + 32'd2;
                        go_base  = base + 32'd2;
                        if (low == 8'h00) begin
                            n_phase = PH_BR16;
                            n_kind  = 1'b0;
                            n_fetch = base + 32'd2;
                        end else if (low == 8'hff) begin
                            n_phase = PH_BR32HI;
                            n_kind  = 1'b0;
                            n_fetch = base + 32'd2;
                        end else begin
                            go       = 1'b1;
                            go_bytes = {{24{low[7]}}, low};
                        end
                    end
                    K_MOVEA: begin
                        if (i_word[13:12] == 2'b11) begin
                            imm = 3'd2; ea_path = 1'b1;
                        end else if (i_word[13:12] == 2'b10) begin
                            imm = 3'd4; ea_path = 1'b1;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    K_ADDA: begin
                        if (i_word[8:6] == 3'b011) begin
                            imm = 3'd2; ea_path = 1'b1;
                        end else if (i_word[8:6] == 3'b111) begin
                            imm = 3'd4; ea_path = 1'b1;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    K_EA: begin
                        ea_path = 1'b1;
                    end
                    default: begin
                        ea_path = 1'b1;
                    end
                endcase
                if (ea_path) begin
                    if (i_word[5:3] == 3'd6 || (i_word[5:3] == 3'd7 && i_word[2:0] == 3'd3))
                    begin
                        // Indexed modes need the brief word before the length is known.
                        n_cursor = base;
                        n_phase  = PH_BRIEF;
                        n_kind   = 1'b0;
                        n_fetch  = base + 32'd2;
                    end else begin
                        go       = 1'b1;
                        go_bytes = {28'd0, ea_words(i_word, 16'd0, imm), 1'b0};
                    end
                end
            end
        end

        if (go) begin
            n_cursor = go_base + go_bytes;
            n_phase  = PH_NEXTOP;
            n_kind   = 1'b0;
            n_fetch  = go_base + go_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth <= 4'd4;
            r_phase     <= PH_IDLE;
            r_cursor    <= 32'd0;
            r_nest      <= 4'd0;
            r_opcode    <= 16'd0;
            r_disp_high <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_max_depth <= i_cfg_wr_data;
            if (accept) begin
                r_phase     <= n_phase;
                r_cursor    <= n_cursor;
                r_nest      <= n_nest;
                r_opcode    <= n_opcode;
                r_disp_high <= n_disp_high;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= n_kind;
            r_fetch <= n_fetch;
            r_mask  <= n_mask;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_fetch_offset = r_fetch;
    assign o_flag_mask    = r_mask;

    // A final result never carries an offset, and a request never carries flags.
    a_final_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> o_fetch_offset == 32'sd0)
        else $error("final result with nonzero offset");
    a_request_no_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |-> o_flag_mask == 5'd0)
        else $error("fetch request with nonzero mask");
    // After a final result the walk is idle until the next item.
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_kind |=> r_phase == PH_IDLE)
        else $error("walk not idle after final result");
    // A stalled result is held, not overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_fetch_offset))
        else $error("stalled result changed");

endmodule
